FILE: src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MMEA_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mmea checker: assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MMEA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mmea checker: assertion failed");

`endif

FILE: src/mmea_pkg.sv
// Shared constants, types and codes of the multi-mouse event aggregator.
`default_nettype none

package mmea_pkg;

  localparam int unsigned MAX_DEVICES = 16;
  localparam int unsigned HANDLE_BITS = 32;
  localparam int unsigned MAX_OUT     = 16;

  localparam int unsigned SLOT_W  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_DEVICES + 1);
  localparam int unsigned LIMIT_W = 5;
  localparam int unsigned CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int unsigned ID_W    = 5;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned PORT_HANDLE_W = 32;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned MOVE_W  = 16;
  localparam int unsigned WHEEL_W = 16;
  localparam int unsigned BTN_N   = 5;
  localparam int unsigned FLAG_W  = 11;
  localparam int unsigned WHEEL_FLAG = 10;

  typedef enum logic [OP_W-1:0] {
    OP_EVENT = 2'd0,
    OP_POLL  = 2'd1,
    OP_EMPTY = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_MOD  = 4'b0100,
    ST_POLL = 4'b1000
  } state_e;

  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [BTN_N-1:0]       btn_t;

  typedef struct packed {
    logic signed [ACC_W-1:0]   acc_x;
    logic signed [ACC_W-1:0]   acc_y;
    logic signed [WHEEL_W-1:0] wheel;
    btn_t                      held;
    btn_t                      press;
    btn_t                      release_b;
  } entry_t;

  typedef struct packed {
    logic  rd_en;
    slot_t rd_addr;
    logic  wr_en;
    slot_t wr_addr;
    logic  clr_frame;
    logic  clr_all;
  } mem_ctrl_t;

  typedef struct packed {
    logic alloc;
    logic clear;
  } dir_ctrl_t;

  typedef struct packed {
    logic  hit;
    logic  full;
    slot_t slot;
    cnt_t  used;
  } dir_stat_t;

endpackage

`default_nettype wire

FILE: src/mmea_dir.sv
// Device directory: handle registers, fill count and parallel handle lookup.
`default_nettype none

module mmea_dir (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mmea_pkg::handle_t   key_i,
  input  mmea_pkg::dir_ctrl_t ctrl_i,
  output mmea_pkg::dir_stat_t stat_o
);

  mmea_pkg::handle_t handle_q [mmea_pkg::MAX_DEVICES];
  mmea_pkg::cnt_t    used_q, used_d;
  logic              hit;
  mmea_pkg::slot_t   hit_slot;

  // Lowest matching slot wins; only slots below the fill count are compared.
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int s = mmea_pkg::MAX_DEVICES - 1; s >= 0; s--) begin
      if ((mmea_pkg::CNT_W'(s) < used_q) && (handle_q[s] == key_i)) begin
        hit      = 1'b1;
        hit_slot = mmea_pkg::SLOT_W'(s);
      end
    end
  end

  assign stat_o.hit  = hit;
  assign stat_o.full = (used_q == mmea_pkg::CNT_W'(mmea_pkg::MAX_DEVICES));
  assign stat_o.slot = hit ? hit_slot : used_q[mmea_pkg::SLOT_W-1:0];
  assign stat_o.used = used_q;

  always_comb begin
    used_d = used_q;
    if (ctrl_i.clear) begin
      used_d = '0;
    end else if (ctrl_i.alloc) begin
      used_d = used_q + mmea_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.alloc) begin
      handle_q[used_q[mmea_pkg::SLOT_W-1:0]] <= key_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/mmea_frame_ram.sv
// Per-slot state memory with valid bits that stand in for the cleared values.
`default_nettype none

module mmea_frame_ram (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mmea_pkg::mem_ctrl_t ctrl_i,
  input  mmea_pkg::entry_t    wdata_i,
  output mmea_pkg::entry_t    rdata_o
);

  mmea_pkg::entry_t                  mem_q [mmea_pkg::MAX_DEVICES];
  mmea_pkg::entry_t                  raw_q;
  logic [mmea_pkg::MAX_DEVICES-1:0]  frame_vld_q;
  logic [mmea_pkg::MAX_DEVICES-1:0]  held_vld_q;
  logic                              frame_rd_q;
  logic                              held_rd_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[ctrl_i.wr_addr] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      raw_q <= mem_q[ctrl_i.rd_addr];
    end
  end

  // Frame bits drop on a poll; held bits survive it and drop only on empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_vld_q <= '0;
      held_vld_q  <= '0;
      frame_rd_q  <= 1'b0;
      held_rd_q   <= 1'b0;
    end else begin
      if (ctrl_i.rd_en) begin
        frame_rd_q <= frame_vld_q[ctrl_i.rd_addr];
        held_rd_q  <= held_vld_q[ctrl_i.rd_addr];
      end
      if (ctrl_i.wr_en) begin
        frame_vld_q[ctrl_i.wr_addr] <= 1'b1;
        held_vld_q[ctrl_i.wr_addr]  <= 1'b1;
      end
      if (ctrl_i.clr_frame || ctrl_i.clr_all) begin
        frame_vld_q <= '0;
      end
      if (ctrl_i.clr_all) begin
        held_vld_q <= '0;
      end
    end
  end

  always_comb begin
    rdata_o = raw_q;
    if (!frame_rd_q) begin
      rdata_o.acc_x     = '0;
      rdata_o.acc_y     = '0;
      rdata_o.wheel     = '0;
      rdata_o.press     = '0;
      rdata_o.release_b = '0;
    end
    if (!held_rd_q) begin
      rdata_o.held = '0;
    end
  end

endmodule

`default_nettype wire

FILE: src/multi_mouse_event_aggregator_top.sv
// Multi-mouse event aggregator: per-device movement, wheel and button tracking.
//
// Command channel: an item is taken at a rising edge with start high and busy
// low. operation selects a mouse event, a poll or emptying the device table.
// Results leave on the result ports for one cycle each, marked by
// result_strobe_o; the receiver cannot stall them.
// A mouse event gives no result and holds busy after it is taken, through the
// lookup state for the handle lookup and the memory read and the modify state
// for the update write, a read-modify-write on the slot memory.
// A new handle that finds the table full is dropped after the lookup; a
// non-mouse event or an unused operation is dropped with no busy time.
// A poll with nothing to emit gives one empty result, taken at the next edge,
// and no busy time. A poll of n entries holds busy while it issues one memory
// read per entry; each result passes the memory output register and the
// result register, and the last busy cycle clears all per-frame values.
// Emptying the table takes effect at once with no busy time.
// Reset empties the table and zeroes all per-slot values; valid bits stand in
// for the zeroes, so no clearing pass is needed.
`default_nettype none

module multi_mouse_event_aggregator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [mmea_pkg::OP_W-1:0]           operation_i,
  input  logic                                is_mouse_i,
  input  logic [mmea_pkg::PORT_HANDLE_W-1:0]  device_handle_i,
  input  logic signed [mmea_pkg::MOVE_W-1:0]  move_x_i,
  input  logic signed [mmea_pkg::MOVE_W-1:0]  move_y_i,
  input  logic [mmea_pkg::FLAG_W-1:0]         button_flags_i,
  input  logic signed [mmea_pkg::WHEEL_W-1:0] wheel_data_i,
  input  logic [mmea_pkg::LIMIT_W-1:0]        poll_limit_i,
  output logic                                result_strobe_o,
  output logic                                entry_valid_o,
  output logic [mmea_pkg::ID_W-1:0]           device_id_o,
  output logic signed [mmea_pkg::ACC_W-1:0]   sum_x_o,
  output logic signed [mmea_pkg::ACC_W-1:0]   sum_y_o,
  output logic signed [mmea_pkg::WHEEL_W-1:0] wheel_value_o,
  output logic [mmea_pkg::BTN_N-1:0]          buttons_held_o,
  output logic [mmea_pkg::BTN_N-1:0]          buttons_pressed_o,
  output logic [mmea_pkg::BTN_N-1:0]          buttons_released_o,
  output logic                                last_entry_o
);

  function automatic logic signed [mmea_pkg::ACC_W-1:0] sat_add(
    input logic signed [mmea_pkg::ACC_W-1:0]  acc,
    input logic signed [mmea_pkg::MOVE_W-1:0] mv
  );
    logic [mmea_pkg::ACC_W:0] s;
    s = {acc[mmea_pkg::ACC_W-1], acc} + (mmea_pkg::ACC_W + 1)'(mv);
    if (s[mmea_pkg::ACC_W] != s[mmea_pkg::ACC_W-1]) begin
      return s[mmea_pkg::ACC_W] ? {1'b1, {(mmea_pkg::ACC_W - 1){1'b0}}}
                                : {1'b0, {(mmea_pkg::ACC_W - 1){1'b1}}};
    end
    return s[mmea_pkg::ACC_W-1:0];
  endfunction

  mmea_pkg::state_e    state_q, state_d;
  mmea_pkg::dir_ctrl_t dir_ctrl;
  mmea_pkg::dir_stat_t dir_stat;
  mmea_pkg::mem_ctrl_t mem_ctrl;
  mmea_pkg::entry_t    rdata, wdata;
  logic                accept;

  // Captured item
  mmea_pkg::handle_t                 key_q;
  logic signed [mmea_pkg::MOVE_W-1:0]  mx_q, my_q;
  logic [mmea_pkg::FLAG_W-1:0]       flags_q;
  logic signed [mmea_pkg::WHEEL_W-1:0] wheel_q;

  mmea_pkg::slot_t slot_q, slot_d;
  mmea_pkg::slot_t idx_q, idx_d;
  mmea_pkg::cnt_t  n_q, n_d;
  logic            issued_q, issued_d;
  logic            rd_q, rd_d;
  mmea_pkg::slot_t rd_idx_q, rd_idx_d;
  logic            rd_last_q, rd_last_d;
  logic            last_issue;

  logic [mmea_pkg::CMP_W-1:0] lim_ext, used_ext, cap_ext, poll_n;

  mmea_pkg::btn_t down, up, held_new;

  // Result register
  logic                                stb_q, stb_d;
  logic                                ev_q, ev_d;
  logic [mmea_pkg::ID_W-1:0]           id_q, id_d;
  logic signed [mmea_pkg::ACC_W-1:0]   sx_q, sx_d, sy_q, sy_d;
  logic signed [mmea_pkg::WHEEL_W-1:0] wv_q, wv_d;
  mmea_pkg::btn_t                      bh_q, bh_d, bp_q, bp_d, br_q, br_d;
  logic                                last_q, last_d;

  mmea_dir u_dir (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_q),
    .ctrl_i (dir_ctrl),
    .stat_o (dir_stat)
  );

  mmea_frame_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mem_ctrl),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign busy   = (state_q != mmea_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Poll count: min(limit, slots used, output capacity)
  always_comb begin
    lim_ext  = mmea_pkg::CMP_W'(poll_limit_i);
    used_ext = mmea_pkg::CMP_W'(dir_stat.used);
    cap_ext  = mmea_pkg::CMP_W'(mmea_pkg::MAX_OUT);
    poll_n   = lim_ext;
    if (used_ext < poll_n) begin
      poll_n = used_ext;
    end
    if (cap_ext < poll_n) begin
      poll_n = cap_ext;
    end
  end

  // Event update: up wins over down.
  always_comb begin
    for (int k = 0; k < mmea_pkg::BTN_N; k++) begin
      down[k] = flags_q[2*k];
      up[k]   = flags_q[2*k+1];
    end
    held_new        = (rdata.held | down) & ~up;
    wdata.acc_x     = sat_add(rdata.acc_x, mx_q);
    wdata.acc_y     = sat_add(rdata.acc_y, my_q);
    wdata.wheel     = flags_q[mmea_pkg::WHEEL_FLAG] ? wheel_q : '0;
    wdata.held      = held_new;
    wdata.press     = held_new & ~rdata.held;
    wdata.release_b = rdata.held & ~held_new;
  end

  assign last_issue = ((mmea_pkg::CNT_W'(idx_q) + mmea_pkg::CNT_W'(1)) == n_q);

  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    idx_d     = idx_q;
    n_d       = n_q;
    issued_d  = issued_q;
    rd_d      = 1'b0;
    rd_idx_d  = rd_idx_q;
    rd_last_d = rd_last_q;
    dir_ctrl  = '0;
    mem_ctrl  = '0;
    stb_d     = 1'b0;
    ev_d      = ev_q;
    id_d      = id_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    wv_d      = wv_q;
    bh_d      = bh_q;
    bp_d      = bp_q;
    br_d      = br_q;
    last_d    = last_q;

    case (state_q)
      mmea_pkg::ST_IDLE: begin
        if (accept) begin
          case (mmea_pkg::op_e'(operation_i))
            mmea_pkg::OP_EVENT: begin
              if (is_mouse_i) begin
                state_d = mmea_pkg::ST_LOOK;
              end
            end
            mmea_pkg::OP_POLL: begin
              if (poll_n == '0) begin
                // Nothing to emit: one empty item, and the frame is cleared.
                stb_d  = 1'b1;
                ev_d   = 1'b0;
                id_d   = '0;
                sx_d   = '0;
                sy_d   = '0;
                wv_d   = '0;
                bh_d   = '0;
                bp_d   = '0;
                br_d   = '0;
                last_d = 1'b1;
                mem_ctrl.clr_frame = 1'b1;
              end else begin
                n_d      = mmea_pkg::CNT_W'(poll_n);
                idx_d    = '0;
                issued_d = 1'b0;
                state_d  = mmea_pkg::ST_POLL;
              end
            end
            mmea_pkg::OP_EMPTY: begin
              dir_ctrl.clear   = 1'b1;
              mem_ctrl.clr_all = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      mmea_pkg::ST_LOOK: begin
        if (dir_stat.hit || !dir_stat.full) begin
          mem_ctrl.rd_en   = 1'b1;
          mem_ctrl.rd_addr = dir_stat.slot;
          dir_ctrl.alloc   = !dir_stat.hit;
          slot_d           = dir_stat.slot;
          state_d          = mmea_pkg::ST_MOD;
        end else begin
          state_d = mmea_pkg::ST_IDLE;
        end
      end

      mmea_pkg::ST_MOD: begin
        mem_ctrl.wr_en   = 1'b1;
        mem_ctrl.wr_addr = slot_q;
        state_d          = mmea_pkg::ST_IDLE;
      end

      mmea_pkg::ST_POLL: begin
        if (!issued_q) begin
          mem_ctrl.rd_en   = 1'b1;
          mem_ctrl.rd_addr = idx_q;
          rd_d             = 1'b1;
          rd_idx_d         = idx_q;
          rd_last_d        = last_issue;
          issued_d         = last_issue;
          idx_d            = idx_q + mmea_pkg::SLOT_W'(1);
        end
        if (rd_q) begin
          stb_d  = 1'b1;
          ev_d   = 1'b1;
          id_d   = mmea_pkg::ID_W'(mmea_pkg::CNT_W'(rd_idx_q) + mmea_pkg::CNT_W'(1));
          sx_d   = rdata.acc_x;
          sy_d   = rdata.acc_y;
          wv_d   = rdata.wheel;
          bh_d   = rdata.held;
          bp_d   = rdata.press;
          br_d   = rdata.release_b;
          last_d = rd_last_q;
          if (rd_last_q) begin
            // All entries read: frame values of every slot go back to zero.
            mem_ctrl.clr_frame = 1'b1;
            state_d            = mmea_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_d = mmea_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mmea_pkg::ST_IDLE;
      issued_q <= 1'b0;
      rd_q     <= 1'b0;
      stb_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      rd_q     <= rd_d;
      stb_q    <= stb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q   <= mmea_pkg::HANDLE_BITS'(device_handle_i);
      mx_q    <= move_x_i;
      my_q    <= move_y_i;
      flags_q <= button_flags_i;
      wheel_q <= wheel_data_i;
    end
    slot_q    <= slot_d;
    idx_q     <= idx_d;
    n_q       <= n_d;
    rd_idx_q  <= rd_idx_d;
    rd_last_q <= rd_last_d;
    ev_q      <= ev_d;
    id_q      <= id_d;
    sx_q      <= sx_d;
    sy_q      <= sy_d;
    wv_q      <= wv_d;
    bh_q      <= bh_d;
    bp_q      <= bp_d;
    br_q      <= br_d;
    last_q    <= last_d;
  end

  assign result_strobe_o    = stb_q;
  assign entry_valid_o      = ev_q;
  assign device_id_o        = id_q;
  assign sum_x_o            = sx_q;
  assign sum_y_o            = sy_q;
  assign wheel_value_o      = wv_q;
  assign buttons_held_o     = bh_q;
  assign buttons_pressed_o  = bp_q;
  assign buttons_released_o = br_q;
  assign last_entry_o       = last_q;

endmodule

`default_nettype wire

FILE: src/mmea_checker.sv
// Port-level checker for the aggregator top level, with its bind.
`default_nettype none

`include "assert_macros.svh"

module mmea_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic [mmea_pkg::OP_W-1:0]           operation_i,
  input logic [mmea_pkg::LIMIT_W-1:0]        poll_limit_i,
  input logic                                result_strobe_o,
  input logic                                entry_valid_o,
  input logic [mmea_pkg::ID_W-1:0]           device_id_o,
  input logic                                last_entry_o
);

  logic acc_ev, acc_poll, acc_zero;

  assign acc_ev   = start && !busy && (operation_i == mmea_pkg::OP_EVENT);
  assign acc_poll = start && !busy && (operation_i == mmea_pkg::OP_POLL);
  assign acc_zero = acc_poll && (poll_limit_i == '0);

  // A mouse event never produces an item.
  `MMEA_ASSERT_NEXT(a_event_silent, acc_ev, !result_strobe_o)

  // A zero-limit poll answers with a single empty item right away.
  `MMEA_ASSERT_NEXT(a_empty_poll, acc_zero, result_strobe_o && !entry_valid_o && last_entry_o && !busy)

  // An empty item is always the last one and carries no device.
  `MMEA_ASSERT(a_empty_last, result_strobe_o && !entry_valid_o, last_entry_o && (device_id_o == '0))

  // A poll either answers at once or keeps the block busy.
  `MMEA_ASSERT_NEXT(a_poll_answers, acc_poll, result_strobe_o || busy)

  // Entries of one poll come out on consecutive cycles.
  `MMEA_ASSERT_NEXT(a_poll_burst, result_strobe_o && entry_valid_o && !last_entry_o, result_strobe_o && entry_valid_o)

endmodule

bind multi_mouse_event_aggregator_top mmea_checker u_mmea_checker (.*);

`default_nettype wire

FILE: sim/mmea_report_checker.sv
// Report checker for the multi-mouse event aggregator: tracks devices, predicts poll output.
module mmea_report_checker
  import mmea_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic                      busy,
  input  logic [OP_W-1:0]           operation_i,
  input  logic                      is_mouse_i,
  input  logic [PORT_HANDLE_W-1:0]  device_handle_i,
  input  logic signed [MOVE_W-1:0]  move_x_i,
  input  logic signed [MOVE_W-1:0]  move_y_i,
  input  logic [FLAG_W-1:0]         button_flags_i,
  input  logic signed [WHEEL_W-1:0] wheel_data_i,
  input  logic [LIMIT_W-1:0]        poll_limit_i,
  input  logic                      result_strobe_o,
  input  logic                      entry_valid_o,
  input  logic [ID_W-1:0]           device_id_o,
  input  logic signed [ACC_W-1:0]   sum_x_o,
  input  logic signed [ACC_W-1:0]   sum_y_o,
  input  logic signed [WHEEL_W-1:0] wheel_value_o,
  input  logic [BTN_N-1:0]          buttons_held_o,
  input  logic [BTN_N-1:0]          buttons_pressed_o,
  input  logic [BTN_N-1:0]          buttons_released_o,
  input  logic                      last_entry_o,
  output int                        fail_count,
  output int                        reports_pending
);

  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;
  localparam int     SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic                      valid;
    logic [ID_W-1:0]           id;
    logic signed [ACC_W-1:0]   sx;
    logic signed [ACC_W-1:0]   sy;
    logic signed [WHEEL_W-1:0] wheel;
    logic [BTN_N-1:0]          held;
    logic [BTN_N-1:0]          pressed;
    logic [BTN_N-1:0]          released;
    logic                      last;
  } mouse_report_t;

  logic [HANDLE_BITS-1:0]    dev_handle   [MAX_DEVICES];
  int                        n_devices;
  logic signed [ACC_W-1:0]   frame_x      [MAX_DEVICES];
  logic signed [ACC_W-1:0]   frame_y      [MAX_DEVICES];
  logic signed [WHEEL_W-1:0] frame_wheel  [MAX_DEVICES];
  logic [BTN_N-1:0]          held_mask    [MAX_DEVICES];
  logic [BTN_N-1:0]          press_mask   [MAX_DEVICES];
  logic [BTN_N-1:0]          release_mask [MAX_DEVICES];
  mouse_report_t             report_q     [$];
  int                        mismatches;

  function automatic void clear_frame_values();
    for (int i = 0; i < MAX_DEVICES; i++) begin
      frame_x[i]      = '0;
      frame_y[i]      = '0;
      frame_wheel[i]  = '0;
      press_mask[i]   = '0;
      release_mask[i] = '0;
    end
  endfunction

  function automatic void forget_devices();
    for (int i = 0; i < MAX_DEVICES; i++) begin
      dev_handle[i] = '0;
      held_mask[i]  = '0;
    end
    n_devices = 0;
    clear_frame_values();
  endfunction

  function automatic logic signed [ACC_W-1:0] saturate(longint v);
    if (v > SUM_MAX) return SUM_MAX[ACC_W-1:0];
    if (v < SUM_MIN) return SUM_MIN[ACC_W-1:0];
    return v[ACC_W-1:0];
  endfunction

  function automatic void fold_event(logic [HANDLE_BITS-1:0] h,
                                     logic signed [MOVE_W-1:0] mx,
                                     logic signed [MOVE_W-1:0] my,
                                     logic [FLAG_W-1:0] flags,
                                     logic signed [WHEEL_W-1:0] wd);
    int         slot;
    bit         hit;
    logic [BTN_N-1:0] dn, up, old, now;
    hit  = 1'b0;
    slot = 0;
    for (int i = 0; i < n_devices; i++)
      if (!hit && dev_handle[i] == h) begin
        hit  = 1'b1;
        slot = i;
      end
    if (!hit) begin
      if (n_devices >= MAX_DEVICES) return;  // table full, new handle dropped
      slot = n_devices;
      dev_handle[slot] = h;
      held_mask[slot]  = '0;
      n_devices++;
    end
    frame_x[slot]     = saturate(longint'(frame_x[slot]) + longint'(mx));
    frame_y[slot]     = saturate(longint'(frame_y[slot]) + longint'(my));
    frame_wheel[slot] = flags[WHEEL_FLAG] ? wd : '0;
    for (int k = 0; k < BTN_N; k++) begin
      dn[k] = flags[2*k];
      up[k] = flags[2*k+1];
    end
    old = held_mask[slot];
    now = (old | dn) & ~up;  // up beats down
    held_mask[slot]    = now;
    press_mask[slot]   = now & ~old;
    release_mask[slot] = old & ~now;
  endfunction

  function automatic void queue_poll(logic [LIMIT_W-1:0] limit);
    int            n;
    mouse_report_t r;
    n = int'(limit);
    if (n > n_devices) n = n_devices;
    if (n > MAX_OUT) n = MAX_OUT;
    if (n == 0) begin
      r      = '0;
      r.last = 1'b1;
      report_q.push_back(r);
    end
    for (int i = 0; i < n; i++) begin
      r.valid    = 1'b1;
      r.id       = ID_W'(i + 1);
      r.sx       = frame_x[i];
      r.sy       = frame_y[i];
      r.wheel    = frame_wheel[i];
      r.held     = held_mask[i];
      r.pressed  = press_mask[i];
      r.released = release_mask[i];
      r.last     = (i + 1 == n);
      report_q.push_back(r);
    end
    clear_frame_values();
  endfunction

  function automatic string report_text(mouse_report_t r);
    return $sformatf("valid=%0b id=%0d x=%0d y=%0d wheel=%0d held=%b pressed=%b released=%b last=%0b",
                     r.valid, r.id, r.sx, r.sy, r.wheel, r.held, r.pressed, r.released, r.last);
  endfunction

  function automatic void check_report();
    mouse_report_t got, want;
    got = '{entry_valid_o, device_id_o, sum_x_o, sum_y_o, wheel_value_o,
            buttons_held_o, buttons_pressed_o, buttons_released_o, last_entry_o};
    if (report_q.size() == 0) begin
      if (mismatches < SHOWN_MISMATCHES)
        $display("unexpected report: %s", report_text(got));
      mismatches++;
      fail_count++;
      return;
    end
    want = report_q.pop_front();
    if (got.valid !== want.valid || got.id !== want.id || got.sx !== want.sx ||
        got.sy !== want.sy || got.wheel !== want.wheel || got.held !== want.held ||
        got.pressed !== want.pressed || got.released !== want.released ||
        got.last !== want.last) begin
      if (mismatches < SHOWN_MISMATCHES) begin
        $display("report mismatch at %0t", $realtime);
        $display("  expected %s", report_text(want));
        $display("  actual   %s", report_text(got));
      end
      mismatches++;
      fail_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      forget_devices();
      report_q.delete();
      mismatches      = 0;
      fail_count      = 0;
      reports_pending = 0;
    end else begin
      // a report at this edge always belongs to an earlier item
      if (result_strobe_o) check_report();
      if (start && !busy) begin
        case (operation_i)
          OP_EVENT: if (is_mouse_i)
                      fold_event(device_handle_i[HANDLE_BITS-1:0], move_x_i, move_y_i,
                                 button_flags_i, wheel_data_i);
          OP_POLL:  queue_poll(poll_limit_i);
          OP_EMPTY: forget_devices();
          default: ;
        endcase
      end
      reports_pending = report_q.size();
    end
  end

endmodule

FILE: sim/tb_multi_mouse_event_aggregator_top.sv
// Testbench top for the multi-mouse event aggregator: stimulus, watchdog and verdict.
module tb_multi_mouse_event_aggregator_top;
  import mmea_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT   = 2000;
  localparam int POOL_N       = 20;
  localparam int RANDOM_ITEMS = 265;
  localparam int SAT_EVENTS   = 16;
  localparam int DRAIN_EVERY  = 50;
  localparam logic [FLAG_W-1:0] ALL_DOWN = 11'h155;
  localparam logic [FLAG_W-1:0] ALL_UP   = 11'h2AA;
  localparam logic [FLAG_W-1:0] WHEEL_ON = 11'h400;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic [OP_W-1:0]           operation_i;
  logic                      is_mouse_i;
  logic [PORT_HANDLE_W-1:0]  device_handle_i;
  logic signed [MOVE_W-1:0]  move_x_i;
  logic signed [MOVE_W-1:0]  move_y_i;
  logic [FLAG_W-1:0]         button_flags_i;
  logic signed [WHEEL_W-1:0] wheel_data_i;
  logic [LIMIT_W-1:0]        poll_limit_i;
  logic                      result_strobe_o;
  logic                      entry_valid_o;
  logic [ID_W-1:0]           device_id_o;
  logic signed [ACC_W-1:0]   sum_x_o;
  logic signed [ACC_W-1:0]   sum_y_o;
  logic signed [WHEEL_W-1:0] wheel_value_o;
  logic [BTN_N-1:0]          buttons_held_o;
  logic [BTN_N-1:0]          buttons_pressed_o;
  logic [BTN_N-1:0]          buttons_released_o;
  logic                      last_entry_o;

  int                        fail_count;
  int                        reports_pending;
  int                        idle_cycles;
  int                        burst_left;
  int                        n;
  int                        pick;
  bit                        gaps_on;
  logic [PORT_HANDLE_W-1:0]  handle_pool [POOL_N];

  multi_mouse_event_aggregator_top DUT (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .is_mouse_i, .device_handle_i,
    .move_x_i, .move_y_i, .button_flags_i, .wheel_data_i, .poll_limit_i,
    .result_strobe_o, .entry_valid_o, .device_id_o, .sum_x_o, .sum_y_o,
    .wheel_value_o, .buttons_held_o, .buttons_pressed_o, .buttons_released_o,
    .last_entry_o
  );

  mmea_report_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .is_mouse_i, .device_handle_i,
    .move_x_i, .move_y_i, .button_flags_i, .wheel_data_i, .poll_limit_i,
    .result_strobe_o, .entry_valid_o, .device_id_o, .sum_x_o, .sum_y_o,
    .wheel_value_o, .buttons_held_o, .buttons_pressed_o, .buttons_released_o,
    .last_entry_o, .fail_count, .reports_pending
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // stall watchdog: no item taken and no report for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_strobe_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL multi_mouse_event_aggregator_top");
        $finish;
      end
    end
  end

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic mouse,
                          input logic [PORT_HANDLE_W-1:0] handle,
                          input logic [MOVE_W-1:0] mx, input logic [MOVE_W-1:0] my,
                          input logic [FLAG_W-1:0] flags, input logic [WHEEL_W-1:0] wheel,
                          input logic [LIMIT_W-1:0] limit);
    int gap;
    @(negedge clk_i);
    if (gaps_on && burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    operation_i     <= op;
    is_mouse_i      <= mouse;
    device_handle_i <= handle;
    move_x_i        <= mx;
    move_y_i        <= my;
    button_flags_i  <= flags;
    wheel_data_i    <= wheel;
    poll_limit_i    <= limit;
    start           <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic mouse_event(input logic [PORT_HANDLE_W-1:0] handle,
                             input logic [MOVE_W-1:0] mx, input logic [MOVE_W-1:0] my,
                             input logic [FLAG_W-1:0] flags, input logic [WHEEL_W-1:0] wheel);
    send_cmd(OP_EVENT, 1'b1, handle, mx, my, flags, wheel,
             LIMIT_W'($urandom_range(0, 16)));
  endtask

  task automatic poll_devices(input logic [LIMIT_W-1:0] limit);
    send_cmd(OP_POLL, 1'($urandom_range(0, 1)), $urandom,
             MOVE_W'($urandom_range(0, 65535)), MOVE_W'($urandom_range(0, 65535)),
             FLAG_W'($urandom_range(0, 2047)), WHEEL_W'($urandom_range(0, 65535)),
             limit);
  endtask

  task automatic empty_table();
    send_cmd(OP_EMPTY, 1'b1, $urandom, 16'h0, 16'h0, 11'h0, 16'h0, 5'd0);
  endtask

  task automatic drain_reports();
    @(negedge clk_i);
    start <= 1'b0;
    while (reports_pending != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    operation_i     = OP_EVENT;
    is_mouse_i      = 1'b0;
    device_handle_i = '0;
    move_x_i        = '0;
    move_y_i        = '0;
    button_flags_i  = '0;
    wheel_data_i    = '0;
    poll_limit_i    = '0;
    burst_left      = 0;
    gaps_on         = 1'b1;
    handle_pool[0]  = 32'h0;
    handle_pool[1]  = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_N; i++) handle_pool[i] = $urandom;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty poll, extremes, ignored items, full table
    poll_devices(5'd5);
    mouse_event(handle_pool[0], 16'h7FFF, 16'h7FFF, ALL_DOWN | WHEEL_ON, 16'h8000);
    mouse_event(handle_pool[1], 16'h8000, 16'h8000, ALL_UP, 16'h7FFF);
    send_cmd(OP_EVENT, 1'b0, handle_pool[19], 16'h1234, 16'h4321, ALL_DOWN, 16'h5, 5'd1);
    mouse_event(handle_pool[0], 16'h0001, 16'hFFFF, ALL_DOWN | ALL_UP | WHEEL_ON, 16'h7FFF);
    send_cmd(OP_UNUSED, 1'b1, handle_pool[2], 16'h7FFF, 16'h7FFF, 11'h7FF, 16'h7FFF, 5'd16);
    poll_devices(5'd16);
    mouse_event(handle_pool[0], 16'h0, 16'h0, ALL_DOWN, 16'h0);
    mouse_event(handle_pool[0], 16'h0, 16'h0, ALL_DOWN, 16'h0);
    poll_devices(5'd0);
    for (int i = 2; i < 16; i++)
      mouse_event(handle_pool[i], MOVE_W'($urandom_range(0, 65535)),
                  MOVE_W'($urandom_range(0, 65535)), FLAG_W'($urandom_range(0, 2047)),
                  WHEEL_W'($urandom_range(0, 65535)));
    // seventeenth handle finds the table full
    mouse_event(handle_pool[16], 16'h10, 16'h20, ALL_DOWN, 16'h30);
    poll_devices(5'd16);
    poll_devices(5'd7);
    poll_devices(5'd16);
    empty_table();
    poll_devices(5'd3);

    // large moves both ways on one device, back to back
    gaps_on = 1'b0;
    for (int i = 0; i < SAT_EVENTS; i++)
      mouse_event(handle_pool[3], 16'h7FFF, 16'h8000, 11'h0, 16'h0);
    poll_devices(5'd1);
    for (int i = 0; i < SAT_EVENTS; i++)
      mouse_event(handle_pool[3], 16'h8000, 16'h7FFF, WHEEL_ON, 16'hFFFF);
    poll_devices(5'd16);
    drain_reports();
    gaps_on = 1'b1;

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 30) gaps_on = !gaps_on;
      if (n % DRAIN_EVERY == DRAIN_EVERY - 1) drain_reports();
      pick = $urandom_range(0, 99);
      if (pick < 62)
        mouse_event(handle_pool[$urandom_range(0, POOL_N - 1)],
                    MOVE_W'($urandom_range(0, 65535)), MOVE_W'($urandom_range(0, 65535)),
                    FLAG_W'($urandom_range(0, 2047)), WHEEL_W'($urandom_range(0, 65535)));
      else if (pick < 68)
        send_cmd(OP_EVENT, 1'b0, handle_pool[$urandom_range(0, POOL_N - 1)],
                 MOVE_W'($urandom_range(0, 65535)), MOVE_W'($urandom_range(0, 65535)),
                 FLAG_W'($urandom_range(0, 2047)), WHEEL_W'($urandom_range(0, 65535)),
                 LIMIT_W'($urandom_range(0, 16)));
      else if (pick < 71)
        mouse_event($urandom, MOVE_W'($urandom_range(0, 65535)),
                    MOVE_W'($urandom_range(0, 65535)), FLAG_W'($urandom_range(0, 2047)),
                    WHEEL_W'($urandom_range(0, 65535)));
      else if (pick < 91)
        poll_devices(LIMIT_W'($urandom_range(0, 16)));
      else if (pick < 93)
        empty_table();
      else if (pick < 96)
        send_cmd(OP_UNUSED, 1'($urandom_range(0, 1)),
                 handle_pool[$urandom_range(0, POOL_N - 1)],
                 MOVE_W'($urandom_range(0, 65535)), MOVE_W'($urandom_range(0, 65535)),
                 FLAG_W'($urandom_range(0, 2047)), WHEEL_W'($urandom_range(0, 65535)),
                 LIMIT_W'($urandom_range(0, 16)));
      else
        poll_devices(5'd16);
    end

    drain_reports();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && reports_pending == 0)
      $display("PASS multi_mouse_event_aggregator_top");
    else
      $display("FAIL multi_mouse_event_aggregator_top");
    $finish;
  end

endmodule
